// ===== hw/rtl/sbq_pkg.sv =====
// Shared constants and types for the stereo biquad, volume and clip block.
`default_nettype none

package sbq_pkg;

   // Field and register widths
   localparam int SAMPLE_W        = 16;
   localparam int COEF_W          = 24;
   localparam int VOL_W           = 16;
   localparam int STATE_W         = 32;
   localparam int CSR_DATA_W      = 24;
   localparam int CSR_INDEX_W     = 3;

   // Fixed-point formats
   localparam int COEF_FRAC_BITS  = 20;
   localparam int STATE_FRAC_BITS = 12;
   localparam int VOL_FRAC_BITS   = 15;
   localparam int OUT_SHIFT       = STATE_FRAC_BITS + VOL_FRAC_BITS;

   // Digit-serial multiply: coefficient and volume go MSB digit first
   localparam int DIGIT_W         = 8;
   localparam int COEF_DIGITS     = COEF_W / DIGIT_W;
   localparam int VOL_DIGITS      = VOL_W / DIGIT_W;
   localparam int CNT_W           = $clog2(COEF_DIGITS);

   // Accumulator widths: filter sum and volume product
   localparam int ACC_W           = 58;
   localparam int SC_W            = STATE_W + VOL_W + 1;

   // Default channel count
   localparam int NUM_CHANNELS_DEF = 2;

   // Register reset values
   localparam logic [VOL_W-1:0]         VOLUME_RST = VOL_W'(6554);
   localparam logic signed [COEF_W-1:0] B0_RST     = COEF_W'(1) << COEF_FRAC_BITS;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE  = 3'd0,
      CSR_VOLUME  = 3'd1,
      CSR_COEF_B0 = 3'd2,
      CSR_COEF_B1 = 3'd3,
      CSR_COEF_B2 = 3'd4,
      CSR_COEF_A1 = 3'd5,
      CSR_COEF_A2 = 3'd6
   } csr_index_type;

   // Sequencer states
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MAC   = 6'b000010,
      S_ROUND = 6'b000100,
      S_VOL   = 6'b001000,
      S_CLIP  = 6'b010000,
      S_HOLD  = 6'b100000
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/stereo_biquad_shelf_volume_clip_top.sv =====
// Interleaved multichannel biquad filter with master volume and 16-bit clipping.
//
// Input channel (req_): one PCM sample per transaction, channels interleaved left
// first; req_tlast marks the last sample of a buffer and restarts at the left channel.
// Result channel (rsp_): one filtered, scaled, saturated sample per input sample,
// with the clip flag on rsp_tuser and the buffer mark echoed on rsp_tlast.
// Configuration (csr_): write enable, register index and data; to be written only when
// idle, which the block itself does not enforce. A filtered sample passes the three-digit
// coefficient loop, the rounding step, the two-digit volume loop and the clip step, using
// 8-bit digit multipliers; a bypassed one (enable low) goes straight to the hold state.
// No new sample is taken until the previous one has left the sequencer.
// A finished result waits in the output register; the next sample is taken while it
// waits, and the sequencer holds its own result only if the register is still full.
// Reset (synchronous, active high) clears all filter delays, selects the left
// channel, restores default registers (enabled, volume about 0.2, pass-through
// coefficients) and empties the output register.
`default_nettype none

module stereo_biquad_shelf_volume_clip_top
   import sbq_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Input samples
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [SAMPLE_W-1:0]    req_tdata,   // [15:0] sample_in
   input  wire logic                   req_tlast,   // last_in_buffer
   // Results
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [SAMPLE_W-1:0]         rsp_tdata,   // [15:0] sample_out
   output logic                        rsp_tuser,   // [0] clipped
   output logic                        rsp_tlast,   // last_out
   // Configuration writes
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam logic signed [ACC_W-1:0] RND_ADD = ACC_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] Y_MAX   = {{(ACC_W-STATE_W){1'b0}}, 32'h7FFF_FFFF};
   localparam logic signed [ACC_W-1:0] Y_MIN   = {{(ACC_W-STATE_W){1'b1}}, 32'h8000_0000};
   localparam logic signed [SC_W-1:0]  CLIP_HI = SC_W'(32'sd32767) <<< OUT_SHIFT;
   localparam logic signed [SC_W-1:0]  CLIP_LO = SC_W'(-32'sd32768) <<< OUT_SHIFT;
   localparam logic signed [SC_W-1:0]  TRUNC_BIAS = (SC_W'(1) << OUT_SHIFT) - SC_W'(1);
   localparam logic [CNT_W-1:0]        COEF_LAST = CNT_W'(COEF_DIGITS - 1);
   localparam logic [CNT_W-1:0]        VOL_LAST  = CNT_W'(VOL_DIGITS - 1);

   // Configuration registers
   logic                     enable_ff;
   logic [VOL_W-1:0]         volume_ff;
   logic signed [COEF_W-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;

   // Per-channel filter delays
   logic signed [SAMPLE_W-1:0] xd1_ff [NUM_CHANNELS];
   logic signed [SAMPLE_W-1:0] xd2_ff [NUM_CHANNELS];
   logic signed [STATE_W-1:0]  yd1_ff [NUM_CHANNELS];
   logic signed [STATE_W-1:0]  yd2_ff [NUM_CHANNELS];

   // Sequencer and working registers
   state_type                  state_ff, state_in;
   logic [CH_W-1:0]            ch_ff, ch_in;
   logic [CH_W-1:0]            wch_ff, wch_in;
   logic [CNT_W-1:0]           dig_ff, dig_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in, x1_ff, x1_in, x2_ff, x2_in;
   logic signed [STATE_W-1:0]  y1_ff, y1_in, y2_ff, y2_in;
   logic [COEF_W-1:0]          sb0_ff, sb0_in, sb1_ff, sb1_in, sb2_ff, sb2_in;
   logic [COEF_W-1:0]          sa1_ff, sa1_in, sa2_ff, sa2_in;
   logic [VOL_W-1:0]           sv_ff, sv_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [STATE_W-1:0]  y_ff, y_in;
   logic signed [SC_W-1:0]     sc_ff, sc_in;
   logic                       last_ff, last_in;
   logic [SAMPLE_W-1:0]        res_ff, res_in;
   logic                       clip_ff, clip_in;

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                       rsp_clip_ff, rsp_clip_in;
   logic                       rsp_last_ff, rsp_last_in;

   // Datapath intermediates
   logic                        accept;
   logic                        slot_free;
   logic                        first_digit;
   logic                        upd_delay;
   logic signed [DIGIT_W:0]     db0, db1, db2, da1, da2, dv;
   logic signed [SAMPLE_W+DIGIT_W:0] pb0, pb1, pb2;
   logic signed [SAMPLE_W+DIGIT_W+2:0] ff_sum;
   logic signed [STATE_W+DIGIT_W:0] pa1, pa2, pv;
   logic signed [ACC_W-1:0]     rnd_sum, y_wide;
   logic signed [STATE_W-1:0]   y_sat;
   logic signed [SC_W-1:0]      sc_trunc;
   logic [SAMPLE_W-1:0]         clip_res;
   logic                        clip_flag;
   logic [CH_W:0]               ch_plus;

   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_clip_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Pick current digits: MSB digit of a coefficient is signed, the rest unsigned
   always_comb begin
      first_digit = (dig_ff == '0);
      db0 = {first_digit & sb0_ff[COEF_W-1], sb0_ff[COEF_W-1 -: DIGIT_W]};
      db1 = {first_digit & sb1_ff[COEF_W-1], sb1_ff[COEF_W-1 -: DIGIT_W]};
      db2 = {first_digit & sb2_ff[COEF_W-1], sb2_ff[COEF_W-1 -: DIGIT_W]};
      da1 = {first_digit & sa1_ff[COEF_W-1], sa1_ff[COEF_W-1 -: DIGIT_W]};
      da2 = {first_digit & sa2_ff[COEF_W-1], sa2_ff[COEF_W-1 -: DIGIT_W]};
      dv  = {1'b0, sv_ff[VOL_W-1 -: DIGIT_W]};
      pb0 = db0 * x_ff;
      pb1 = db1 * x1_ff;
      pb2 = db2 * x2_ff;
      pa1 = da1 * y1_ff;
      pa2 = da2 * y2_ff;
      pv  = dv * y_ff;
      ff_sum = (SAMPLE_W+DIGIT_W+3)'(pb0) + (SAMPLE_W+DIGIT_W+3)'(pb1)
             + (SAMPLE_W+DIGIT_W+3)'(pb2);
   end

   // Round to nearest and saturate the filter output to 32 bits
   always_comb begin
      rnd_sum = acc_ff + RND_ADD;
      y_wide  = rnd_sum >>> COEF_FRAC_BITS;
      priority if (y_wide > Y_MAX) begin
         y_sat = Y_MAX[STATE_W-1:0];
      end else if (y_wide < Y_MIN) begin
         y_sat = Y_MIN[STATE_W-1:0];
      end else begin
         y_sat = y_wide[STATE_W-1:0];
      end
   end

   // Clip the scaled value, else truncate its fraction toward zero
   always_comb begin
      sc_trunc = (sc_ff + (sc_ff[SC_W-1] ? TRUNC_BIAS : '0)) >>> OUT_SHIFT;
      priority if (sc_ff > CLIP_HI) begin
         clip_res  = SAMPLE_W'(16'h7FFF);
         clip_flag = 1'b1;
      end else if (sc_ff < CLIP_LO) begin
         clip_res  = SAMPLE_W'(16'h8000);
         clip_flag = 1'b1;
      end else begin
         clip_res  = sc_trunc[SAMPLE_W-1:0];
         clip_flag = 1'b0;
      end
   end

   // Sequencer and working registers
   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      wch_in   = wch_ff;
      dig_in   = dig_ff;
      x_in     = x_ff;
      x1_in    = x1_ff;
      x2_in    = x2_ff;
      y1_in    = y1_ff;
      y2_in    = y2_ff;
      sb0_in   = sb0_ff;
      sb1_in   = sb1_ff;
      sb2_in   = sb2_ff;
      sa1_in   = sa1_ff;
      sa2_in   = sa2_ff;
      sv_in    = sv_ff;
      acc_in   = acc_ff;
      y_in     = y_ff;
      sc_in    = sc_ff;
      last_in  = last_ff;
      res_in   = res_ff;
      clip_in  = clip_ff;
      upd_delay = 1'b0;
      ch_plus  = {1'b0, ch_ff} + (CH_W+1)'(1);

      // Drop the output transaction once taken
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_clip_in  = rsp_clip_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Load operands, advance channel position
               wch_in  = ch_ff;
               x_in    = req_tdata;
               last_in = req_tlast;
               x1_in   = xd1_ff[ch_ff];
               x2_in   = xd2_ff[ch_ff];
               y1_in   = yd1_ff[ch_ff];
               y2_in   = yd2_ff[ch_ff];
               sb0_in  = b0_ff;
               sb1_in  = b1_ff;
               sb2_in  = b2_ff;
               sa1_in  = a1_ff;
               sa2_in  = a2_ff;
               sv_in   = volume_ff;
               acc_in  = '0;
               sc_in   = '0;
               dig_in  = '0;
               if (req_tlast || (ch_plus >= (CH_W+1)'(NUM_CHANNELS))) begin
                  ch_in = '0;
               end else begin
                  ch_in = ch_plus[CH_W-1:0];
               end
               if (enable_ff) begin
                  state_in = S_MAC;
               end else begin
                  res_in   = req_tdata;
                  clip_in  = 1'b0;
                  state_in = S_HOLD;
               end
            end
         end
         S_MAC: begin
            // Accumulate one coefficient digit of all five products
            acc_in = (acc_ff <<< DIGIT_W)
                   + (ACC_W'(ff_sum) <<< STATE_FRAC_BITS)
                   - ACC_W'(pa1) - ACC_W'(pa2);
            sb0_in = sb0_ff << DIGIT_W;
            sb1_in = sb1_ff << DIGIT_W;
            sb2_in = sb2_ff << DIGIT_W;
            sa1_in = sa1_ff << DIGIT_W;
            sa2_in = sa2_ff << DIGIT_W;
            dig_in = dig_ff + CNT_W'(1);
            if (dig_ff == COEF_LAST) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            y_in      = y_sat;
            upd_delay = 1'b1;
            dig_in    = '0;
            state_in  = S_VOL;
         end
         S_VOL: begin
            // Accumulate one volume digit
            sc_in  = (sc_ff <<< DIGIT_W) + SC_W'(pv);
            sv_in  = sv_ff << DIGIT_W;
            dig_in = dig_ff + CNT_W'(1);
            if (dig_ff == VOL_LAST) begin
               state_in = S_CLIP;
            end
         end
         S_CLIP: begin
            res_in  = clip_res;
            clip_in = clip_flag;
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = clip_res;
               rsp_clip_in  = clip_flag;
               rsp_last_in  = last_ff;
               state_in     = S_IDLE;
            end else begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_clip_in  = clip_ff;
               rsp_last_in  = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control, configuration and delay state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b1;
         volume_ff    <= VOLUME_RST;
         b0_ff        <= B0_RST;
         b1_ff        <= '0;
         b2_ff        <= '0;
         a1_ff        <= '0;
         a2_ff        <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            xd1_ff[i] <= '0;
            xd2_ff[i] <= '0;
            yd1_ff[i] <= '0;
            yd2_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
         // Register writes; unknown indexes are ignored
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ENABLE:  enable_ff <= csr_wdata[0];
               CSR_VOLUME:  volume_ff <= csr_wdata[VOL_W-1:0];
               CSR_COEF_B0: b0_ff     <= csr_wdata[COEF_W-1:0];
               CSR_COEF_B1: b1_ff     <= csr_wdata[COEF_W-1:0];
               CSR_COEF_B2: b2_ff     <= csr_wdata[COEF_W-1:0];
               CSR_COEF_A1: a1_ff     <= csr_wdata[COEF_W-1:0];
               CSR_COEF_A2: a2_ff     <= csr_wdata[COEF_W-1:0];
               default: ;
            endcase
         end
         // Shift the delay line of the item's channel
         if (upd_delay) begin
            xd2_ff[wch_ff] <= x1_ff;
            xd1_ff[wch_ff] <= x_ff;
            yd2_ff[wch_ff] <= y1_ff;
            yd1_ff[wch_ff] <= y_sat;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      wch_ff      <= wch_in;
      dig_ff      <= dig_in;
      x_ff        <= x_in;
      x1_ff       <= x1_in;
      x2_ff       <= x2_in;
      y1_ff       <= y1_in;
      y2_ff       <= y2_in;
      sb0_ff      <= sb0_in;
      sb1_ff      <= sb1_in;
      sb2_ff      <= sb2_in;
      sa1_ff      <= sa1_in;
      sa2_ff      <= sa2_in;
      sv_ff       <= sv_in;
      acc_ff      <= acc_in;
      y_ff        <= y_in;
      sc_ff       <= sc_in;
      last_ff     <= last_in;
      res_ff      <= res_in;
      clip_ff     <= clip_in;
      rsp_data_ff <= rsp_data_in;
      rsp_clip_ff <= rsp_clip_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTHESIS
   // No second sample is taken right after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("sample accepted while previous one in work");

   // Digit counter stays within the coefficient digits
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MAC |-> dig_ff <= COEF_LAST)
      else $error("coefficient digit counter out of range");

   // A held result waits while the output register is stalled
   a_hold_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD && rsp_valid_ff && !rsp_tready) |=> state_ff == S_HOLD)
      else $error("held result left while output stalled");

   // Channel position stays within the channel count
   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, ch_ff} < (CH_W+1)'(NUM_CHANNELS))
      else $error("channel position out of range");
`endif

endmodule

`default_nettype wire
